[rtl/core/aescbc_pkg.sv]
// ============================================================================
// aescbc_pkg
// shared types, constants and byte functions of the aes-256 cbc cipher unit
// ============================================================================
package aescbc_pkg;

    localparam int NumRounds = 14;
    localparam int NumRkWords = 60;

    typedef logic [1:0] action_t;
    localparam action_t ACT_RESTART = 2'd0;
    localparam action_t ACT_ENCRYPT = 2'd1;
    localparam action_t ACT_DECRYPT = 2'd2;

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_KEY0 = 3'd0;
    localparam reg_idx_t REG_KEY1 = 3'd1;
    localparam reg_idx_t REG_KEY2 = 3'd2;
    localparam reg_idx_t REG_KEY3 = 3'd3;
    localparam reg_idx_t REG_IVH  = 3'd4;
    localparam reg_idx_t REG_IVL  = 3'd5;

    typedef logic [7:0] sbox_arr_t [256];
    localparam sbox_arr_t SboxTab = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] sbox(input logic [7:0] a);
        return SboxTab[a];
    endfunction

    // inverse table built at elaboration
    function automatic sbox_arr_t build_inv();
        sbox_arr_t t;
        for (int k = 0; k < 256; k++) begin
            t[SboxTab[k]] = 8'(k);
        end
        return t;
    endfunction

    localparam sbox_arr_t InvSboxTab = build_inv();

    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        return InvSboxTab[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

endpackage

[rtl/core/aescbc_key_sched.sv]
// ============================================================================
// aescbc_key_sched
// key expansion: one 32-bit round-key word per cycle into a round-key memory
// ============================================================================
module aescbc_key_sched
    import aescbc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [255:0] key,
    input  logic [3:0]   rd_round,
    output logic [127:0] rd_key,
    output logic         busy
);

    logic [127:0] rk_mem [NumRounds + 1];
    logic [255:0] win_reg, win_next;
    logic [5:0]   idx_reg, idx_next;
    logic [7:0]   rcon_reg, rcon_next;
    logic         busy_reg, busy_next;
    logic [31:0]  t_word, new_word;
    logic         wr_en;

    always_comb
    begin
        t_word = win_reg[31:0];
        if (idx_reg[2:0] == 3'd0) begin
            t_word = sub_word({t_word[23:0], t_word[31:24]}) ^ {rcon_reg, 24'h0};
        end else if (idx_reg[2:0] == 3'd4) begin
            t_word = sub_word(t_word);
        end
        new_word  = win_reg[255:224] ^ t_word;
        win_next  = win_reg;
        idx_next  = idx_reg;
        rcon_next = rcon_reg;
        busy_next = busy_reg;
        wr_en     = 1'b0;
        if (start) begin
            win_next  = key;
            idx_next  = 6'd8;
            rcon_next = 8'h01;
            busy_next = 1'b1;
            wr_en     = 1'b1;
        end else if (busy_reg) begin
            win_next = {win_reg[223:0], new_word};
            idx_next = idx_reg + 6'd1;
            if (idx_reg[2:0] == 3'd0) begin
                rcon_next = xtime(rcon_reg);
            end
            wr_en = (idx_reg[1:0] == 2'd3);
            if (idx_reg == 6'(NumRkWords - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            rcon_reg <= 8'h01;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            rcon_reg <= rcon_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    // rounds 0 and 1 written at start, later rounds every fourth word
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            if (start) begin
                rk_mem[0] <= key[255:128];
                rk_mem[1] <= key[127:0];
            end else begin
                rk_mem[idx_reg[5:2]] <= {win_reg[95:0], new_word};
            end
        end
        rd_key <= rk_mem[rd_round];
    end

    assign busy = busy_reg;

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg >= 6'd8 && idx_reg <= 6'(NumRkWords - 1)))
        else $error("key index out of range");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("expansion did not start");
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start && idx_reg == 6'(NumRkWords - 1)) |=> !busy_reg)
        else $error("expansion did not finish");
`endif

endmodule

[rtl/core/aescbc_round.sv]
// ============================================================================
// aescbc_round
// shared round datapath: one forward or inverse aes round per use
// ============================================================================
module aescbc_round
    import aescbc_pkg::*;
(
    input  logic         decrypt,
    input  logic         last,
    input  logic [127:0] state_in,
    input  logic [127:0] round_key,
    output logic [127:0] state_out
);

    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] u [16];
    logic [7:0] m [16];
    logic [7:0] a0, a1, a2, a3, x2_0, x2_1, x2_2, x2_3;
    logic [7:0] x4_0, x4_1, x4_2, x4_3, x8_0, x8_1, x8_2, x8_3;

    always_comb
    begin
        for (int i = 0; i < 16; i++) begin
            s[i] = state_in[127 - 8*i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                if (decrypt) begin
                    t[((c + i) & 3) * 4 + i] = inv_sbox(s[c*4 + i]);
                end else begin
                    t[c*4 + i] = sbox(s[((c + i) & 3) * 4 + i]);
                end
            end
        end
        // decrypt adds the key before the inverse mix
        for (int i = 0; i < 16; i++) begin
            u[i] = decrypt ? (t[i] ^ round_key[127 - 8*i -: 8]) : t[i];
        end
        for (int c = 0; c < 4; c++) begin
            a0 = u[c*4]; a1 = u[c*4+1]; a2 = u[c*4+2]; a3 = u[c*4+3];
            x2_0 = xtime(a0); x2_1 = xtime(a1); x2_2 = xtime(a2); x2_3 = xtime(a3);
            x4_0 = xtime(x2_0); x4_1 = xtime(x2_1); x4_2 = xtime(x2_2); x4_3 = xtime(x2_3);
            x8_0 = xtime(x4_0); x8_1 = xtime(x4_1); x8_2 = xtime(x4_2); x8_3 = xtime(x4_3);
            if (last) begin
                m[c*4] = a0; m[c*4+1] = a1; m[c*4+2] = a2; m[c*4+3] = a3;
            end else if (decrypt) begin
                m[c*4]   = (x8_0^x4_0^x2_0) ^ (x8_1^x2_1^a1) ^ (x8_2^x4_2^a2) ^ (x8_3^a3);
                m[c*4+1] = (x8_0^a0) ^ (x8_1^x4_1^x2_1) ^ (x8_2^x2_2^a2) ^ (x8_3^x4_3^a3);
                m[c*4+2] = (x8_0^x4_0^a0) ^ (x8_1^a1) ^ (x8_2^x4_2^x2_2) ^ (x8_3^x2_3^a3);
                m[c*4+3] = (x8_0^x2_0^a0) ^ (x8_1^x4_1^a1) ^ (x8_2^a2) ^ (x8_3^x4_3^x2_3);
            end else begin
                m[c*4]   = x2_0 ^ x2_1 ^ a1 ^ a2 ^ a3;
                m[c*4+1] = a0 ^ x2_1 ^ x2_2 ^ a2 ^ a3;
                m[c*4+2] = a0 ^ a1 ^ x2_2 ^ x2_3 ^ a3;
                m[c*4+3] = x2_0 ^ a0 ^ a1 ^ a2 ^ x2_3;
            end
        end
        for (int i = 0; i < 16; i++) begin
            state_out[127 - 8*i -: 8] = decrypt ? m[i] : (m[i] ^ round_key[127 - 8*i -: 8]);
        end
    end

endmodule

[rtl/core/aes256_cbc_cipher_unit.sv]
// ============================================================================
// aes256_cbc_cipher_unit
// aes-256 cipher in cbc mode with one shared round unit and a round-key memory
// ============================================================================
// channel | direction | fields                        | handshake
// in      | input     | action, block_high, block_low | in_valid / in_stall
// out     | output    | out_high, out_low             | out_valid / out_stall
// cfg     | input     | key and iv registers          | apb, 8-byte stride
//
// encrypt or decrypt: accept with the first key read, then whitening, then
// 14 rounds through the shared round unit
// restart: one expanded key word per cycle
// after reset the block is ready at once; a waiting result holds in the output
// register while the next transaction runs, whose last round waits for it
module aes256_cbc_cipher_unit
    import aescbc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [1:0]   action,
    input  logic [63:0]  block_high,
    input  logic [63:0]  block_low,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [63:0]  out_high,
    output logic [63:0]  out_low,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_KEY   = 4'b0010,
        ST_FETCH = 4'b0100,
        ST_ROUND = 4'b1000
    } state_t;

    state_t       state_reg, state_next;
    logic [63:0]  cfg_reg [6];
    logic [127:0] chain_reg, chain_next;
    logic [127:0] data_reg, data_next;
    logic [127:0] cin_reg, cin_next;
    logic         dec_reg, dec_next;
    logic [3:0]   rnd_reg, rnd_next;
    logic         ov_reg, ov_next;
    logic [127:0] res_reg, res_next;
    logic         ks_start, ks_busy;
    logic [3:0]   rd_round;
    logic [127:0] rd_key, rnd_out;
    logic         last;
    reg_idx_t     widx;
    logic         in_acc;

    assign pready = 1'b1;
    assign widx = reg_idx_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < 6; i++) begin
                cfg_reg[i] <= '0;
            end
        end else if (psel && penable && pwrite && paddr[5:3] <= REG_IVL) begin
            cfg_reg[widx] <= pwdata;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[5:3] <= REG_IVL) begin
            prdata = cfg_reg[widx];
        end
    end

    aescbc_key_sched u_ks (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ks_start),
        .key      ({cfg_reg[REG_KEY0], cfg_reg[REG_KEY1],
                    cfg_reg[REG_KEY2], cfg_reg[REG_KEY3]}),
        .rd_round (rd_round),
        .rd_key   (rd_key),
        .busy     (ks_busy)
    );

    assign last = dec_reg ? (rnd_reg == 4'd0) : (rnd_reg == 4'(NumRounds));

    aescbc_round u_rnd (
        .decrypt   (dec_reg),
        .last      (last),
        .state_in  (data_reg),
        .round_key (rd_key),
        .state_out (rnd_out)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        chain_next = chain_reg;
        data_next  = data_reg;
        cin_next   = cin_reg;
        dec_next   = dec_reg;
        rnd_next   = rnd_reg;
        ov_next    = ov_reg && out_stall;
        res_next   = res_reg;
        ks_start   = 1'b0;
        rd_round   = rnd_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc) begin
                    cin_next = {block_high, block_low};
                    if (action == ACT_RESTART) begin
                        chain_next = {cfg_reg[REG_IVH], cfg_reg[REG_IVL]};
                        ks_start   = 1'b1;
                        state_next = ST_KEY;
                    end else if (action == ACT_ENCRYPT) begin
                        data_next  = {block_high, block_low} ^ chain_reg;
                        dec_next   = 1'b0;
                        rnd_next   = 4'd0;
                        rd_round   = 4'd0;
                        state_next = ST_FETCH;
                    end else if (action == ACT_DECRYPT) begin
                        data_next  = {block_high, block_low};
                        dec_next   = 1'b1;
                        rnd_next   = 4'(NumRounds);
                        rd_round   = 4'(NumRounds);
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_KEY:
            begin
                if (!ks_busy) begin
                    state_next = ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                // whitening key is in rd_key; add it and fetch the first round key
                data_next  = data_reg ^ rd_key;
                rnd_next   = dec_reg ? rnd_reg - 4'd1 : rnd_reg + 4'd1;
                rd_round   = rnd_next;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (!last) begin
                    data_next = rnd_out;
                    rnd_next  = dec_reg ? rnd_reg - 4'd1 : rnd_reg + 4'd1;
                    rd_round  = rnd_next;
                end else if (!(ov_reg && out_stall)) begin
                    if (dec_reg) begin
                        res_next   = rnd_out ^ chain_reg;
                        chain_next = cin_reg;
                    end else begin
                        res_next   = rnd_out;
                        chain_next = rnd_out;
                    end
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            chain_reg <= '0;
            ov_reg    <= 1'b0;
            rnd_reg   <= '0;
            dec_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            chain_reg <= chain_next;
            ov_reg    <= ov_next;
            rnd_reg   <= rnd_next;
            dec_reg   <= dec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        cin_reg  <= cin_next;
        res_reg  <= res_next;
    end

    assign out_valid = ov_reg;
    assign out_high  = res_reg[127:64];
    assign out_low   = res_reg[63:0];

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("transaction taken while busy");
    a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && last && !(ov_reg && out_stall))
            |=> (out_valid && state_reg == ST_IDLE))
        else $error("result not delivered");
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (rnd_reg <= 4'(NumRounds)))
        else $error("round counter out of range");
    a_key_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ks_busy |-> (state_reg == ST_KEY))
        else $error("key expansion overlaps cipher");
`endif

endmodule

[tb/aes256_cbc_cipher_unit_test.sv]
`timescale 1ns / 100ps
// ============================================================================
// aes256_cbc_cipher_unit_test
// drives restart, encrypt, decrypt and unused-action transactions through the cipher under
// random idling and a long output hold-off; a local aes-256 cbc predictor
// computes every result, and the cipher scoreboard compares them in order
// ============================================================================
module aes256_cbc_cipher_unit_test;
    import aescbc_pkg::*;

    typedef logic [7:0] blk_bytes_t [16];

    class cbc_scoreboard;
        logic [63:0] want_high [$];
        logic [63:0] want_low [$];
        int errors;

        function void note_block(logic [63:0] h, logic [63:0] l);
            want_high.push_back(h);
            want_low.push_back(l);
        endfunction

        function int pending();
            return want_high.size();
        endfunction

        task check_block(logic [63:0] h, logic [63:0] l);
            logic [63:0] eh;
            logic [63:0] el;
            if (want_high.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %h_%h", h, l));
                return;
            end
            eh = want_high.pop_front();
            el = want_low.pop_front();
            if (h !== eh)
                report_mismatch($sformatf("out_high %h, want %h", h, eh));
            if (l !== el)
                report_mismatch($sformatf("out_low %h, want %h", l, el));
        endtask

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] out_high;
    logic [63:0] out_low;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    cbc_scoreboard board;
    logic [63:0] key_regs [4];
    logic [63:0] iv_regs [2];
    logic [7:0]  round_key [240];
    logic [63:0] chain [2];
    int          cycles;
    bit          hold_off;
    bit          stim_done;

    aes256_cbc_cipher_unit dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [7:0] mul8(logic [7:0] a, logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                r ^= a;
            a = xtime(a);
        end
        return r;
    endfunction

    function automatic logic [7:0] inv_sb(logic [7:0] v);
        for (int k = 0; k < 256; k++)
            if (SboxTab[k] == v)
                return 8'(k);
        return 8'h00;
    endfunction

    function automatic blk_bytes_t to_bytes(logic [63:0] h, logic [63:0] l);
        blk_bytes_t s;
        for (int i = 0; i < 8; i++)
        begin
            s[i] = h[63 - 8 * i -: 8];
            s[i + 8] = l[63 - 8 * i -: 8];
        end
        return s;
    endfunction

    function automatic logic [127:0] from_bytes(blk_bytes_t s);
        logic [127:0] w;
        for (int i = 0; i < 16; i++)
            w[127 - 8 * i -: 8] = s[i];
        return w;
    endfunction

    function automatic void expand_round_keys();
        logic [7:0] t [4];
        logic [7:0] tmp;
        logic [7:0] rcon;
        rcon = 8'h01;
        for (int i = 0; i < 32; i++)
            round_key[i] = key_regs[i / 8][63 - 8 * (i % 8) -: 8];
        for (int i = 8; i < 60; i++)
        begin
            for (int j = 0; j < 4; j++)
                t[j] = round_key[(i - 1) * 4 + j];
            if (i % 8 == 0)
            begin
                tmp = t[0]; t[0] = t[1]; t[1] = t[2]; t[2] = t[3]; t[3] = tmp;
                for (int j = 0; j < 4; j++)
                    t[j] = SboxTab[t[j]];
                t[0] ^= rcon;
                rcon = xtime(rcon);
            end
            else if (i % 8 == 4)
            begin
                for (int j = 0; j < 4; j++)
                    t[j] = SboxTab[t[j]];
            end
            for (int j = 0; j < 4; j++)
                round_key[i * 4 + j] = round_key[(i - 8) * 4 + j] ^ t[j];
        end
    endfunction

    function automatic void add_key(ref blk_bytes_t s, input int r);
        for (int i = 0; i < 16; i++)
            s[i] ^= round_key[16 * r + i];
    endfunction

    function automatic blk_bytes_t encipher(blk_bytes_t s);
        blk_bytes_t t;
        logic [7:0] a0, a1, a2, a3;
        add_key(s, 0);
        for (int r = 1; r <= NumRounds; r++)
        begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    t[c * 4 + i] = SboxTab[s[((c + i) & 3) * 4 + i]];
            if (r < NumRounds)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
                    s[c*4]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
                    s[c*4+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
                    s[c*4+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
                    s[c*4+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
                end
            end
            else
                s = t;
            add_key(s, r);
        end
        return s;
    endfunction

    function automatic blk_bytes_t decipher(blk_bytes_t s);
        blk_bytes_t t;
        logic [7:0] a0, a1, a2, a3;
        add_key(s, NumRounds);
        for (int r = NumRounds - 1; r >= 0; r--)
        begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    t[((c + i) & 3) * 4 + i] = inv_sb(s[c * 4 + i]);
            s = t;
            add_key(s, r);
            if (r > 0)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = s[c*4]; a1 = s[c*4+1]; a2 = s[c*4+2]; a3 = s[c*4+3];
                    s[c*4]   = mul8(a0, 8'd14) ^ mul8(a1, 8'd11) ^ mul8(a2, 8'd13)
                               ^ mul8(a3, 8'd9);
                    s[c*4+1] = mul8(a0, 8'd9) ^ mul8(a1, 8'd14) ^ mul8(a2, 8'd11)
                               ^ mul8(a3, 8'd13);
                    s[c*4+2] = mul8(a0, 8'd13) ^ mul8(a1, 8'd9) ^ mul8(a2, 8'd14)
                               ^ mul8(a3, 8'd11);
                    s[c*4+3] = mul8(a0, 8'd11) ^ mul8(a1, 8'd13) ^ mul8(a2, 8'd9)
                               ^ mul8(a3, 8'd14);
                end
            end
        end
        return s;
    endfunction

    function automatic void predict_cbc(logic [1:0] act, logic [63:0] h, logic [63:0] l);
        logic [127:0] res;
        case (act)
            ACT_RESTART:
            begin
                chain[0] = iv_regs[0];
                chain[1] = iv_regs[1];
                expand_round_keys();
            end
            ACT_ENCRYPT:
            begin
                res = from_bytes(encipher(to_bytes(h ^ chain[0], l ^ chain[1])));
                chain[0] = res[127:64];
                chain[1] = res[63:0];
                board.note_block(res[127:64], res[63:0]);
            end
            ACT_DECRYPT:
            begin
                res = from_bytes(decipher(to_bytes(h, l)));
                board.note_block(res[127:64] ^ chain[0], res[63:0] ^ chain[1]);
                chain[0] = h;
                chain[1] = l;
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic wait_cycles(int n);
        repeat (n) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [63:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 6'(idx) << 3;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx <= REG_KEY3)
            key_regs[idx] = val;
        else
            iv_regs[idx - REG_IVH] = val;
        @(posedge clk);
    endtask

    task automatic send_item(logic [1:0] act, logic [63:0] h, logic [63:0] l);
        int gap;
        if ($urandom_range(0, 3) == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
            in_valid <= 1'b0;
            wait_cycles(gap);
        end
        in_valid <= 1'b1;
        action <= act;
        block_high <= h;
        block_low <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_cbc(act, h, l);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        wait_cycles(70);
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 64'h0;
            1: return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic load_config(bit mode);
        for (int i = 0; i < 6; i++)
            write_reg(reg_idx_t'(i), mode ? rand_word() : (i % 2 ? '1 : 64'h0));
    endtask

    task automatic rand_item();
        int pick;
        logic [1:0] act;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            act = ACT_RESTART;
        else if (pick < 5)
            act = 2'd3;
        else
            act = (pick < 52) ? ACT_ENCRYPT : ACT_DECRYPT;
        send_item(act, rand_word(), rand_word());
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_RESTART;
        block_high = '0;
        block_low = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        stim_done = 1'b0;
        key_regs = '{default: '0};
        iv_regs = '{default: '0};
        chain = '{default: '0};
        wait_cycles(3);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: all-zero key first, then fixed patterns
        send_item(ACT_RESTART, '0, '0);
        send_item(ACT_ENCRYPT, '0, '0);
        send_item(ACT_ENCRYPT, '1, '1);
        send_item(2'd3, '1, '1);
        send_item(ACT_DECRYPT, '0, '0);
        send_item(ACT_DECRYPT, '1, '1);
        settle();
        load_config(1'b0);
        send_item(ACT_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_item(ACT_RESTART, '0, '0);
        send_item(ACT_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_item(ACT_DECRYPT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        send_item(ACT_RESTART, '1, '1);
        send_item(ACT_DECRYPT, '1, '0);
        settle();
        for (int i = 0; i < 6; i++)
            write_reg(reg_idx_t'(i), '1);
        send_item(ACT_RESTART, '0, '0);
        send_item(ACT_ENCRYPT, '0, '1);
        send_item(ACT_DECRYPT, '0, '1);
        settle();

        for (int phase = 0; phase < 6; phase++)
        begin
            load_config(1'b1);
            send_item(ACT_RESTART, rand_word(), rand_word());
            if (phase == 2)
                hold_off = 1'b1;
            for (int n = 0; n < 250; n++)
                rand_item();
            settle();
        end
        stim_done = 1'b1;
    end

    // long output hold-off with the sender still pushing, then random output stalls
    initial
    begin
        int held;
        hold_off = 1'b0;
        out_stall = 1'b0;
        @(posedge hold_off);
        held = 0;
        out_stall <= 1'b1;
        while (held < 400)
        begin
            @(posedge clk);
            held++;
        end
        out_stall <= 1'b0;
        hold_off = 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 199) == 0)
            begin
                out_stall <= 1'b1;
                wait_cycles($urandom_range(20, 80));
            end
            else if ($urandom_range(0, 2) == 0)
                out_stall <= 1'b1;
            else if ($urandom_range(0, 1) == 0)
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_block(out_high, out_low);
    end

    initial
    begin
        cycles = 0;
        while (!stim_done && cycles < 600000)
        begin
            @(posedge clk);
            cycles++;
        end
        if (stim_done && board.pending() == 0 && board.errors == 0)
            $display("aes256_cbc_cipher_unit_test OK");
        else
        begin
            if (board.pending() != 0)
                $display("%0d results never arrived", board.pending());
            $display("aes256_cbc_cipher_unit_test NOT OK");
        end
        $finish;
    end
endmodule

[sim.f]
rtl/core/aescbc_pkg.sv
rtl/core/aescbc_key_sched.sv
rtl/core/aescbc_round.sv
rtl/core/aes256_cbc_cipher_unit.sv
tb/aes256_cbc_cipher_unit_test.sv
